// ===== sv/assert_macros.svh =====
// Assertion macros shared by the frame deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check prop at every rising edge of clk outside reset.
`define ASSERT_AT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("frame deframer assertion failed");
// Check that cond never holds outside reset.
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("frame deframer forbidden condition seen");
`else
`define ASSERT_AT(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

// ===== sv/lrcd_pkg.sv =====
// Types, constants and helpers for the LRC frame deframer.
package lrcd_pkg;

    localparam int POS_W = 17;

    localparam logic [7:0] SOF_BYTE  = 8'h11;
    localparam logic [7:0] LRC1_BYTE = 8'h00 - SOF_BYTE;
    localparam int         LRC2_SPAN = 6;

    // Byte positions inside the frame
    localparam logic [POS_W-1:0] POS_SOF      = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LRC1     = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CMD_HI   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CMD_LO   = POS_W'(3);
    localparam logic [POS_W-1:0] POS_STAT_HI  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_STAT_LO  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_LRC2     = POS_W'(2 + LRC2_SPAN);
    localparam logic [POS_W-1:0] DATA_START   = POS_W'(9);
    localparam logic [POS_W-1:0] MIN_FRAME    = POS_W'(10);

    // Result kinds
    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes, in check order
    localparam logic [2:0] ERR_OK          = 3'd0;
    localparam logic [2:0] ERR_TOO_SHORT   = 3'd1;
    localparam logic [2:0] ERR_BAD_SOF     = 3'd2;
    localparam logic [2:0] ERR_BAD_LRC1    = 3'd3;
    localparam logic [2:0] ERR_BAD_LRC2    = 3'd4;
    localparam logic [2:0] ERR_LEN_EXCEEDS = 3'd5;
    localparam logic [2:0] ERR_BAD_LRC3    = 3'd6;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam int OUT_TDATA_W = 64;
    localparam int OUT_FIELD_W = 8 + 3 + 16 + 16 + 16;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [2:0]  error_code;
        logic [15:0] command;
        logic [15:0] frame_status;
        logic [15:0] payload_length;
    } result_t;

    function automatic result_t make_data(input logic [7:0] b);
        result_t r;
        r              = '0;
        r.kind         = KIND_DATA;
        r.payload_byte = b;
        return r;
    endfunction

    // Header fields go out only with an ok verdict.
    function automatic result_t make_verdict(input logic [2:0]  code,
                                             input logic [15:0] cmd,
                                             input logic [15:0] stat,
                                             input logic [15:0] len);
        result_t r;
        r            = '0;
        r.kind       = KIND_VERDICT;
        r.error_code = code;
        if (code == ERR_OK)
        begin
            r.command        = cmd;
            r.frame_status   = stat;
            r.payload_length = len;
        end
        return r;
    endfunction

endpackage

// ===== sv/lrc_frame_deframer_top.sv =====
// Top level of the SOF / length / LRC frame deframer.
// Usage:
//   The slave stream takes one received byte per transfer in s_axis_tdata,
//   with s_axis_tlast marking the final byte of the buffer. The master stream
//   gives results: m_axis_tuser 0 is a data byte passed out as it arrives,
//   1 is the single verdict of the buffer (error code, plus command, status
//   and length when the frame is good).
//   Path: each byte is held in the input register, then the check logic
//   writes its results into the result queue, from which they are offered.
//   Throughput: one byte per cycle while the queue has room (s_axis_tready
//   high); the check step is combinational. A final byte that ends a short
//   data section yields two results, the data byte and the length verdict,
//   which drain one per cycle while m_axis_tready is high.
//   Reset clears the frame state and empties the result queue; the block
//   is then waiting for the SOF of a new buffer.
//   When the receiver stalls, results wait in a four-entry queue; the input
//   keeps taking bytes while the queue has room for two more results and
//   then holds s_axis_tready low until it drains.
//   Bytes after a verdict are dropped until the end-of-buffer byte.
module lrc_frame_deframer_top
    import lrcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    input  logic                   s_axis_tlast,   // end_of_buffer
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] payload_byte, [10:8] error_code, [26:11] command,
    // [42:27] frame_status, [58:43] payload_length, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser    // kind
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eob_reg;
    logic       room;
    logic       fire;
    logic [1:0] push_n;
    result_t    res0;
    result_t    res1;
    result_t    out_res;

    assign fire          = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eob_reg  <= s_axis_tlast;
        end
    end

    lrcd_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (fire),
        .rx_byte       (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .push_n        (push_n),
        .res0          (res0),
        .res1          (res1)
    );

    lrcd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .res0      (res0),
        .res1      (res1),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}},
                           out_res.payload_length,
                           out_res.frame_status,
                           out_res.command,
                           out_res.error_code,
                           out_res.payload_byte};

endmodule

// ===== sv/lrcd_core.sv =====
// Frame check state and per-byte result generation.
`include "assert_macros.svh"
module lrcd_core
    import lrcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       end_of_buffer,
    output logic [1:0] push_n,
    output result_t    res0,
    output result_t    res1
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       hv_reg, hv_next;
    logic [7:0]       hsum_reg, hsum_next;
    logic [7:0]       dsum_reg, dsum_next;
    logic [15:0]      cmd_reg, cmd_next;
    logic [15:0]      stat_reg, stat_next;
    logic [15:0]      len_reg, len_next;
    logic             given_reg, given_next;

    logic             main_valid;
    result_t          main_res;
    logic             eob_valid;
    result_t          eob_res;

    always_comb
    begin
        pos_next   = pos_reg;
        hv_next    = hv_reg;
        hsum_next  = hsum_reg;
        dsum_next  = dsum_reg;
        cmd_next   = cmd_reg;
        stat_next  = stat_reg;
        len_next   = len_reg;
        given_next = given_reg;
        main_valid = 1'b0;
        main_res   = '0;
        eob_valid  = 1'b0;
        eob_res    = '0;

        if (step && !given_reg)
        begin
            if (pos_reg == POS_SOF)
            begin
                if (rx_byte != SOF_BYTE && hv_reg == ERR_OK)
                    hv_next = ERR_BAD_SOF;
            end
            else if (pos_reg == POS_LRC1)
            begin
                if (rx_byte != LRC1_BYTE && hv_reg == ERR_OK)
                    hv_next = ERR_BAD_LRC1;
            end
            else if (pos_reg < POS_LRC2)
            begin
                hsum_next = hsum_reg + rx_byte;
                case (pos_reg)
                    POS_CMD_HI:  cmd_next[15:8]  = rx_byte;
                    POS_CMD_LO:  cmd_next[7:0]   = rx_byte;
                    POS_STAT_HI: stat_next[15:8] = rx_byte;
                    POS_STAT_LO: stat_next[7:0]  = rx_byte;
                    POS_LEN_HI:  len_next[15:8]  = rx_byte;
                    default:     len_next[7:0]   = rx_byte;
                endcase
            end
            else if (pos_reg == POS_LRC2)
            begin
                if (rx_byte != (8'h00 - hsum_reg) && hv_reg == ERR_OK)
                    hv_next = ERR_BAD_LRC2;
            end
            else if (hv_reg != ERR_OK)
            begin
                // report the header error once the full header is in
                main_valid = 1'b1;
                main_res   = make_verdict(hv_reg, cmd_reg, stat_reg, len_reg);
                given_next = 1'b1;
            end
            else if ((pos_reg - DATA_START) < {1'b0, len_reg})
            begin
                dsum_next  = dsum_reg + rx_byte;
                main_valid = 1'b1;
                main_res   = make_data(rx_byte);
            end
            else
            begin
                main_valid = 1'b1;
                main_res   = make_verdict((rx_byte == (8'h00 - dsum_reg)) ?
                                          ERR_OK : ERR_BAD_LRC3,
                                          cmd_reg, stat_reg, len_reg);
                given_next = 1'b1;
            end
            pos_next = pos_reg + POS_W'(1);
        end

        if (step && end_of_buffer)
        begin
            if (!given_next)
            begin
                eob_valid = 1'b1;
                eob_res   = make_verdict((pos_next < MIN_FRAME) ?
                                         ERR_TOO_SHORT : ERR_LEN_EXCEEDS,
                                         cmd_reg, stat_reg, len_reg);
            end
            // clear everything for the next buffer
            pos_next   = '0;
            hv_next    = ERR_OK;
            hsum_next  = '0;
            dsum_next  = '0;
            cmd_next   = '0;
            stat_next  = '0;
            len_next   = '0;
            given_next = 1'b0;
        end
    end

    always_comb
    begin
        push_n = {1'b0, main_valid} + {1'b0, eob_valid};
        res0   = main_valid ? main_res : eob_res;
        res1   = eob_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hv_reg    <= ERR_OK;
            hsum_reg  <= '0;
            dsum_reg  <= '0;
            cmd_reg   <= '0;
            stat_reg  <= '0;
            len_reg   <= '0;
            given_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            hv_reg    <= hv_next;
            hsum_reg  <= hsum_next;
            dsum_reg  <= dsum_next;
            cmd_reg   <= cmd_next;
            stat_reg  <= stat_next;
            len_reg   <= len_next;
            given_reg <= given_next;
        end
    end

    `ASSERT_AT(a_two_results_need_eob, (step && push_n == 2'd2) |-> end_of_buffer)
    `ASSERT_AT(a_eob_clears_state, (step && end_of_buffer) |=> (pos_reg == '0 && !given_reg))
    `ASSERT_NEVER(a_verdict_twice, given_reg && step && push_n != 2'd0)

endmodule

// ===== sv/lrcd_result_fifo.sv =====
// Small result queue that takes up to two results per cycle and gives one per cycle while out_ready is high.
`include "assert_macros.svh"
module lrcd_result_fifo
    import lrcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  result_t    res0,
    input  result_t    res1,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_res
);

    result_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    pop;

    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // room for a full two-result step, judged on the registered count
    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            entry_reg[wr_ptr_reg] <= res0;
        if (push_n == 2'd2)
            entry_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_AT(a_count_in_range, count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `ASSERT_AT(a_push_fits, (push_n != 2'd0) |-> ({1'b0, count_reg} + 4'(push_n) <= 4'(FIFO_DEPTH)))
    `ASSERT_AT(a_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == FIFO_PTR_W'(count_reg))

endmodule
